>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the look-at view matrix RTL.
// No dependencies; the macros collapse to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define LAV_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg)
`define LAV_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/lav_pkg.sv
// Types, widths, latencies and rounding helpers of the look-at view matrix unit.
// No dependencies; every RTL file of the block but lav_delay refers to it by scoped names.
package lav_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int BASIS_W   = FRAC_W + 2;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROJ_W    = DATA_W + 4;
    localparam int SCALE_W   = 31;
    localparam int SQ_W      = 2 * SCALE_W + 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int NUM_W     = SCALE_W + FRAC_W + 3;
    localparam int QUO_W     = FRAC_W + 1;

    localparam int ISQRT_LAT = ROOT_W;
    localparam int DIV_LAT   = QUO_W;
    localparam int NORM_LAT  = 5 + ISQRT_LAT + 1 + DIV_LAT + 1;
    localparam int PROJ_LAT  = 6;
    localparam int BASIS_LAT = 6;
    localparam int OUT_LAT   = 1 + NORM_LAT + PROJ_LAT + NORM_LAT + BASIS_LAT;

    localparam logic [QUO_W-1:0] UNIT_Q = QUO_W'(1) << FRAC_W;

    typedef logic signed [BASIS_W-1:0] t_basis;
    typedef logic signed [DATA_W-1:0]  t_data;

    // Divide by 2^FRAC_W, rounding half away from zero.
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
        logic signed [63:0] half;
        half = 64'sd1 <<< (FRAC_W - 1);
        if (v >= 0) begin
            round_frac = (v + half) >>> FRAC_W;
        end else begin
            round_frac = -((-v + half) >>> FRAC_W);
        end
    endfunction

    function automatic t_basis clamp_unit(input logic signed [63:0] v);
        logic signed [63:0] one;
        one = 64'sd1 <<< FRAC_W;
        if (v > one) begin
            clamp_unit = BASIS_W'(one);
        end else if (v < -one) begin
            clamp_unit = BASIS_W'(-one);
        end else begin
            clamp_unit = BASIS_W'(v);
        end
    endfunction

    // Negated, rounded dot product saturated to the data range.
    function automatic t_data neg_round_sat(input logic signed [63:0] v);
        logic signed [63:0] r, hi, lo;
        r  = -round_frac(v);
        hi = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (r > hi) begin
            neg_round_sat = DATA_W'(hi);
        end else if (r < lo) begin
            neg_round_sat = DATA_W'(lo);
        end else begin
            neg_round_sat = DATA_W'(r);
        end
    endfunction

endpackage

>>> hw/rtl/lav_delay.sv
// Fixed-length delay line that keeps side data aligned with pipelined results.
// No dependencies.
module lav_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

>>> hw/rtl/lav_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on lav_pkg.
module lav_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lav_pkg::SQ_W-1:0]    i_sq,
    output logic                        o_valid,
    output logic [lav_pkg::ROOT_W-1:0]  o_root
);

    localparam int SQ_W   = lav_pkg::SQ_W;
    localparam int ROOT_W = lav_pkg::ROOT_W;

    logic [SQ_W-1:0]   r_rem [ROOT_W];
    logic [SQ_W-1:0]   r_res [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [SQ_W-1:0] rem_in, res_in, bit_s, trial;
        if (s == 0) begin : g_first
            assign rem_in = i_sq;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign res_in = r_res[s-1];
        end
        assign bit_s = SQ_W'(1) << (SQ_W - 2 - 2 * s);
        assign trial = res_in + bit_s;

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[s] <= rem_in - trial;
                r_res[s] <= (res_in >> 1) + bit_s;
            end else begin
                r_rem[s] <= rem_in;
                r_res[s] <= res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];

endmodule

>>> hw/rtl/lav_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lav_pkg; the quotient must fit in QUO_W bits.
module lav_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lav_pkg::NUM_W-1:0]   i_num,
    input  logic [lav_pkg::ROOT_W-1:0]  i_den,
    output logic                        o_valid,
    output logic [lav_pkg::QUO_W-1:0]   o_quo
);

    localparam int NUM_W = lav_pkg::NUM_W;
    localparam int DEN_W = lav_pkg::ROOT_W;
    localparam int QUO_W = lav_pkg::QUO_W;

    logic [NUM_W-1:0] r_num [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [QUO_W-1:0] r_vld;

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NUM_W-1:0] num_in, dsh;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        if (s == 0) begin : g_first
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end
        assign dsh = NUM_W'(den_in) << (QUO_W - 1 - s);

        always_ff @(posedge i_clk) begin
            r_den[s] <= den_in;
            if (num_in >= dsh) begin
                r_num[s] <= num_in - dsh;
                r_quo[s] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - s));
            end else begin
                r_num[s] <= num_in;
                r_quo[s] <= quo_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QUO_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

>>> hw/rtl/lav_norm.sv
// Pipelined normalizer of a signed 3-vector to unit length in Q1.FRAC_W.
// Depends on lav_pkg, lav_delay, lav_isqrt and lav_div.
module lav_norm #(
    parameter int IN_W = 33
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [IN_W-1:0] i_v [3],
    output logic                   o_valid,
    output lav_pkg::t_basis        o_u [3]
);

    localparam int SCALE_W = lav_pkg::SCALE_W;
    localparam int SQ_W    = lav_pkg::SQ_W;
    localparam int ROOT_W  = lav_pkg::ROOT_W;
    localparam int NUM_W   = lav_pkg::NUM_W;
    localparam int QUO_W   = lav_pkg::QUO_W;
    localparam int FRAC_W  = lav_pkg::FRAC_W;
    localparam int POS_W   = $clog2(IN_W);
    localparam int SIDE_D  = lav_pkg::ISQRT_LAT + 3 + lav_pkg::DIV_LAT;

    // Stage A: magnitudes and signs.
    logic [IN_W-1:0] r_mag_a [3];
    logic [2:0]      r_neg_a;
    logic            r_va;
    // Stage B: position of the leading one over all three magnitudes.
    logic [IN_W-1:0] r_mag_b [3];
    logic [2:0]      r_neg_b;
    logic [POS_W-1:0] r_msb;
    logic            r_zero_b;
    logic            r_vb;
    logic [IN_W-1:0] mag_or;
    logic [POS_W-1:0] n_msb;
    // Stage C: magnitudes scaled so the largest lies in [2^30, 2^31).
    logic [SCALE_W-1:0] r_sc [3];
    logic [3:0]         r_side_c;
    logic               r_vc;
    logic [SCALE_W-1:0] n_sc [3];
    // Stages D and E: squares and their sum.
    logic [SQ_W-1:0] r_sq [3];
    logic            r_vd;
    logic [SQ_W-1:0] r_n2;
    logic            r_ve;
    // Root, then numerators for the three divisions.
    logic              root_v;
    logic [ROOT_W-1:0] root;
    logic [3*SCALE_W-1:0] sc_bus, sc_d_bus;
    logic [NUM_W-1:0]  r_num [3];
    logic [ROOT_W-1:0] r_den;
    logic              r_vn;
    logic [2:0]        div_v;
    logic [QUO_W-1:0]  quo [3];
    logic [3:0]        side_d;
    logic              r_vo;
    lav_pkg::t_basis   r_u [3];

    always_comb begin
        mag_or = r_mag_a[0] | r_mag_a[1] | r_mag_a[2];
        n_msb  = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (mag_or[b]) begin
                n_msb = POS_W'(b);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_msb > POS_W'(SCALE_W - 1)) begin
                n_sc[i] = SCALE_W'(r_mag_b[i] >> (r_msb - POS_W'(SCALE_W - 1)));
            end else begin
                n_sc[i] = SCALE_W'({{SCALE_W{1'b0}}, r_mag_b[i]}
                                   << (POS_W'(SCALE_W - 1) - r_msb));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag_a[i] <= i_v[i][IN_W-1] ? IN_W'(-i_v[i]) : IN_W'(i_v[i]);
            r_neg_a[i] <= i_v[i][IN_W-1];
            r_mag_b[i] <= r_mag_a[i];
            r_sc[i]    <= n_sc[i];
            r_sq[i]    <= SQ_W'(r_sc[i]) * SQ_W'(r_sc[i]);
        end
        r_neg_b  <= r_neg_a;
        r_msb    <= n_msb;
        r_zero_b <= (mag_or == '0);
        r_side_c <= {r_zero_b, r_neg_b};
        r_n2     <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    lav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ve),
        .i_sq    (r_n2),
        .o_valid (root_v),
        .o_root  (root)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sc_bus[i*SCALE_W +: SCALE_W] = r_sc[i];
        end
    end

    lav_delay #(.WIDTH(3 * SCALE_W), .DEPTH(lav_pkg::ISQRT_LAT + 2)) u_sc_dly (
        .i_clk (i_clk),
        .i_d   (sc_bus),
        .o_q   (sc_d_bus)
    );

    lav_delay #(.WIDTH(4), .DEPTH(SIDE_D)) u_side_dly (
        .i_clk (i_clk),
        .i_d   (r_side_c),
        .o_q   (side_d)
    );

    // Adding half the divisor rounds the quotient half up.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= (NUM_W'(sc_d_bus[i*SCALE_W +: SCALE_W]) << FRAC_W)
                        + NUM_W'(root[ROOT_W-1:1]);
        end
        r_den <= root;
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        lav_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_vn),
            .i_num   (r_num[i]),
            .i_den   (r_den),
            .o_valid (div_v[i]),
            .o_quo   (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (side_d[3]) begin
                r_u[i] <= '0;
            end else if (side_d[i]) begin
                r_u[i] <= -lav_pkg::t_basis'({1'b0, (quo[i] > lav_pkg::UNIT_Q)
                                                    ? lav_pkg::UNIT_Q : quo[i]});
            end else begin
                r_u[i] <= lav_pkg::t_basis'({1'b0, (quo[i] > lav_pkg::UNIT_Q)
                                                   ? lav_pkg::UNIT_Q : quo[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vn <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vn <= root_v;
            r_vo <= div_v[0];
        end
    end

    assign o_valid = r_vo;
    assign o_u     = r_u;

endmodule

>>> hw/rtl/look_at_view_matrix_unit.sv
// Look-at view matrix unit: from an eye point, a target point and an up vector
// (signed Q16.16) it forms the unit line of sight, the orthonormalized up vector,
// the right vector and the saturated translation row. The unit is a fixed
// pipeline: one request is taken in every cycle, busy never rises, and each
// result appears on the output ports with o_valid high for one cycle. Most of
// the delay lies in the two normalizers in series, each with a 32-stage square
// root and a 17-stage divider. The receiver cannot stall the unit and must
// take every result as it appears.
// Depends on lav_pkg, lav_delay, lav_norm and assert_macros.svh.
`include "assert_macros.svh"

module look_at_view_matrix_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lav_pkg::t_data         i_eye_x,
    input  lav_pkg::t_data         i_eye_y,
    input  lav_pkg::t_data         i_eye_z,
    input  lav_pkg::t_data         i_target_x,
    input  lav_pkg::t_data         i_target_y,
    input  lav_pkg::t_data         i_target_z,
    input  lav_pkg::t_data         i_upward_x,
    input  lav_pkg::t_data         i_upward_y,
    input  lav_pkg::t_data         i_upward_z,
    output logic                   o_valid,
    output lav_pkg::t_basis        o_right_x,
    output lav_pkg::t_basis        o_right_y,
    output lav_pkg::t_basis        o_right_z,
    output lav_pkg::t_basis        o_ortho_up_x,
    output lav_pkg::t_basis        o_ortho_up_y,
    output lav_pkg::t_basis        o_ortho_up_z,
    output lav_pkg::t_basis        o_view_dir_x,
    output lav_pkg::t_basis        o_view_dir_y,
    output lav_pkg::t_basis        o_view_dir_z,
    output lav_pkg::t_data         o_shift_x,
    output lav_pkg::t_data         o_shift_y,
    output lav_pkg::t_data         o_shift_z
);

    localparam int DATA_W  = lav_pkg::DATA_W;
    localparam int BASIS_W = lav_pkg::BASIS_W;
    localparam int DIFF_W  = lav_pkg::DIFF_W;
    localparam int PROJ_W  = lav_pkg::PROJ_W;
    localparam int NL      = lav_pkg::NORM_LAT;
    localparam int P1_W    = DATA_W + BASIS_W;
    localparam int P2_W    = P1_W + 2;
    localparam int T_W     = P2_W - lav_pkg::FRAC_W + 1;
    localparam int P4_W    = BASIS_W + T_W;
    localparam int Q1_W    = 2 * BASIS_W;
    localparam int Q2_W    = Q1_W + 1;
    localparam int Q4_W    = DATA_W + BASIS_W;
    localparam int Q5_W    = Q4_W + 2;
    localparam int D3_W    = 3 * DATA_W;
    localparam int B3_W    = 3 * BASIS_W;

    lav_pkg::t_data eye [3];
    lav_pkg::t_data tgt [3];
    lav_pkg::t_data upw [3];
    logic [D3_W-1:0] eye_bus, upw_bus, u_p0_bus, u_p5_bus, e_q3_bus;

    logic signed [DIFF_W-1:0] r_d [3];
    logic                     r_v1;

    logic            dn_v;
    lav_pkg::t_basis dn_p0 [3];
    lav_pkg::t_basis dn_p3 [3];
    lav_pkg::t_basis dn_q0 [3];
    lav_pkg::t_data  u_p0 [3];
    lav_pkg::t_data  u_p5 [3];
    lav_pkg::t_data  e_q3 [3];
    logic [B3_W-1:0] dn_p0_bus, dn_p3_bus, dn_q0_bus;

    // Projection of up onto the line of sight, and up with that projection taken out.
    logic signed [P1_W-1:0]   r_p1 [3];
    logic signed [P2_W-1:0]   r_p2;
    logic signed [T_W-1:0]    r_p3;
    logic signed [P4_W-1:0]   r_p4 [3];
    logic signed [PROJ_W-1:0] r_p5 [3];
    logic signed [PROJ_W-1:0] r_p6 [3];
    logic [5:0]               r_pv;

    logic            un_v;
    lav_pkg::t_basis un_q0 [3];
    lav_pkg::t_basis un_q3 [3];
    lav_pkg::t_basis dn_q3 [3];
    lav_pkg::t_basis un_q5 [3];
    lav_pkg::t_basis dn_q5 [3];
    lav_pkg::t_basis rt_q5 [3];
    logic [2*B3_W-1:0] ud_q0_bus, ud_q3_bus;
    logic [3*B3_W-1:0] rud_q3_bus, rud_q5_bus;

    // Cross product and translation.
    logic signed [Q1_W-1:0] r_q1 [6];
    logic signed [Q2_W-1:0] r_q2 [3];
    lav_pkg::t_basis        r_q3 [3];
    logic signed [Q4_W-1:0] r_q4 [9];
    logic signed [Q5_W-1:0] r_q5 [3];
    lav_pkg::t_basis        r_o_rt [3];
    lav_pkg::t_basis        r_o_un [3];
    lav_pkg::t_basis        r_o_dn [3];
    lav_pkg::t_data         r_o_sh [3];
    logic [5:0]             r_qv;

    assign busy = 1'b0;

    assign eye[0] = i_eye_x;
    assign eye[1] = i_eye_y;
    assign eye[2] = i_eye_z;
    assign tgt[0] = i_target_x;
    assign tgt[1] = i_target_y;
    assign tgt[2] = i_target_z;
    assign upw[0] = i_upward_x;
    assign upw[1] = i_upward_y;
    assign upw[2] = i_upward_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i] <= DIFF_W'(tgt[i]) - DIFF_W'(eye[i]);
        end
    end

    lav_norm #(.IN_W(DIFF_W)) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_v     (r_d),
        .o_valid (dn_v),
        .o_u     (dn_p0)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            eye_bus[i*DATA_W +: DATA_W]     = eye[i];
            upw_bus[i*DATA_W +: DATA_W]     = upw[i];
            dn_p0_bus[i*BASIS_W +: BASIS_W] = dn_p0[i];
            ud_q0_bus[i*BASIS_W +: BASIS_W]          = un_q0[i];
            ud_q0_bus[B3_W + i*BASIS_W +: BASIS_W]   = dn_q0[i];
            rud_q3_bus[i*BASIS_W +: BASIS_W]         = r_q3[i];
            rud_q3_bus[B3_W + i*BASIS_W +: BASIS_W]  = un_q3[i];
            rud_q3_bus[2*B3_W + i*BASIS_W +: BASIS_W] = dn_q3[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_p0[i]  = u_p0_bus[i*DATA_W +: DATA_W];
            u_p5[i]  = u_p5_bus[i*DATA_W +: DATA_W];
            e_q3[i]  = e_q3_bus[i*DATA_W +: DATA_W];
            dn_p3[i] = dn_p3_bus[i*BASIS_W +: BASIS_W];
            dn_q0[i] = dn_q0_bus[i*BASIS_W +: BASIS_W];
            un_q3[i] = ud_q3_bus[i*BASIS_W +: BASIS_W];
            dn_q3[i] = ud_q3_bus[B3_W + i*BASIS_W +: BASIS_W];
            rt_q5[i] = rud_q5_bus[i*BASIS_W +: BASIS_W];
            un_q5[i] = rud_q5_bus[B3_W + i*BASIS_W +: BASIS_W];
            dn_q5[i] = rud_q5_bus[2*B3_W + i*BASIS_W +: BASIS_W];
        end
    end

    lav_delay #(.WIDTH(D3_W), .DEPTH(1 + NL)) u_up_p0_dly (
        .i_clk (i_clk), .i_d (upw_bus), .o_q (u_p0_bus)
    );
    lav_delay #(.WIDTH(D3_W), .DEPTH(NL + lav_pkg::PROJ_LAT)) u_up_p5_dly (
        .i_clk (i_clk), .i_d (upw_bus), .o_q (u_p5_bus)
    );
    lav_delay #(.WIDTH(D3_W), .DEPTH(lav_pkg::OUT_LAT - 3)) u_eye_dly (
        .i_clk (i_clk), .i_d (eye_bus), .o_q (e_q3_bus)
    );
    lav_delay #(.WIDTH(B3_W), .DEPTH(3)) u_dn_p3_dly (
        .i_clk (i_clk), .i_d (dn_p0_bus), .o_q (dn_p3_bus)
    );
    lav_delay #(.WIDTH(B3_W), .DEPTH(lav_pkg::PROJ_LAT + NL)) u_dn_q0_dly (
        .i_clk (i_clk), .i_d (dn_p0_bus), .o_q (dn_q0_bus)
    );
    lav_delay #(.WIDTH(2 * B3_W), .DEPTH(3)) u_ud_q3_dly (
        .i_clk (i_clk), .i_d (ud_q0_bus), .o_q (ud_q3_bus)
    );
    lav_delay #(.WIDTH(3 * B3_W), .DEPTH(2)) u_rud_q5_dly (
        .i_clk (i_clk), .i_d (rud_q3_bus), .o_q (rud_q5_bus)
    );

    // t is the rounded dot product of up with the unit line of sight.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p1[i] <= P1_W'(u_p0[i]) * P1_W'(dn_p0[i]);
            r_p4[i] <= P4_W'(dn_p3[i]) * P4_W'(r_p3);
            r_p5[i] <= PROJ_W'(lav_pkg::round_frac(64'(r_p4[i])));
            r_p6[i] <= PROJ_W'(u_p5[i]) - r_p5[i];
        end
        r_p2 <= P2_W'(r_p1[0]) + P2_W'(r_p1[1]) + P2_W'(r_p1[2]);
        r_p3 <= T_W'(lav_pkg::round_frac(64'(r_p2)));
    end

    lav_norm #(.IN_W(PROJ_W)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv[5]),
        .i_v     (r_p6),
        .o_valid (un_v),
        .o_u     (un_q0)
    );

    always_ff @(posedge i_clk) begin
        r_q1[0] <= Q1_W'(un_q0[1]) * Q1_W'(dn_q0[2]);
        r_q1[1] <= Q1_W'(un_q0[2]) * Q1_W'(dn_q0[1]);
        r_q1[2] <= Q1_W'(un_q0[2]) * Q1_W'(dn_q0[0]);
        r_q1[3] <= Q1_W'(un_q0[0]) * Q1_W'(dn_q0[2]);
        r_q1[4] <= Q1_W'(un_q0[0]) * Q1_W'(dn_q0[1]);
        r_q1[5] <= Q1_W'(un_q0[1]) * Q1_W'(dn_q0[0]);
        for (int i = 0; i < 3; i++) begin
            r_q2[i]     <= Q2_W'(r_q1[2*i]) - Q2_W'(r_q1[2*i+1]);
            r_q3[i]     <= lav_pkg::clamp_unit(lav_pkg::round_frac(64'(r_q2[i])));
            r_q4[i]     <= Q4_W'(e_q3[i]) * Q4_W'(r_q3[i]);
            r_q4[3+i]   <= Q4_W'(e_q3[i]) * Q4_W'(un_q3[i]);
            r_q4[6+i]   <= Q4_W'(e_q3[i]) * Q4_W'(dn_q3[i]);
            r_q5[i]     <= Q5_W'(r_q4[3*i]) + Q5_W'(r_q4[3*i+1]) + Q5_W'(r_q4[3*i+2]);
            r_o_sh[i]   <= lav_pkg::neg_round_sat(64'(r_q5[i]));
            r_o_rt[i]   <= rt_q5[i];
            r_o_un[i]   <= un_q5[i];
            r_o_dn[i]   <= dn_q5[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_pv <= '0;
            r_qv <= '0;
        end else begin
            r_v1 <= start && !busy;
            r_pv <= {r_pv[4:0], dn_v};
            r_qv <= {r_qv[4:0], un_v};
        end
    end

    assign o_valid      = r_qv[5];
    assign o_right_x    = r_o_rt[0];
    assign o_right_y    = r_o_rt[1];
    assign o_right_z    = r_o_rt[2];
    assign o_ortho_up_x = r_o_un[0];
    assign o_ortho_up_y = r_o_un[1];
    assign o_ortho_up_z = r_o_un[2];
    assign o_view_dir_x = r_o_dn[0];
    assign o_view_dir_y = r_o_dn[1];
    assign o_view_dir_z = r_o_dn[2];
    assign o_shift_x    = r_o_sh[0];
    assign o_shift_y    = r_o_sh[1];
    assign o_shift_z    = r_o_sh[2];

    // Every result traces back to a request a fixed number of cycles earlier.
    `LAV_ASSERT(a_fixed_latency, i_clk, i_rst_n, o_valid |-> $past(start, lav_pkg::OUT_LAT), "result without a matching request")
    // A zero orthonormalized up vector leaves right and the translation terms of right and up zero as well.
    `LAV_ASSERT(a_zero_up, i_clk, i_rst_n, (o_valid && o_ortho_up_x == '0 && o_ortho_up_y == '0 && o_ortho_up_z == '0) |-> (o_right_x == '0 && o_right_y == '0 && o_right_z == '0 && o_shift_x == '0 && o_shift_y == '0), "zero up vector gave nonzero right")
    // Sight components never leave [-1.0, +1.0].
    `LAV_NEVER(a_dir_range, i_clk, i_rst_n, o_valid && (o_view_dir_x > 18'sd65536 || o_view_dir_x < -18'sd65536 || o_view_dir_y > 18'sd65536 || o_view_dir_y < -18'sd65536 || o_view_dir_z > 18'sd65536 || o_view_dir_z < -18'sd65536), "line of sight component out of range")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the look-at view matrix unit.
// Depends on lav_pkg and look_at_view_matrix_unit; a scoreboard class holds
// the predicted camera bases and compares them with the unit's results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        lav_pkg::t_basis rx, ry, rz, ux, uy, uz, dx, dy, dz;
        lav_pkg::t_data  sx, sy, sz;
    } t_frame;

    class frame_scoreboard;
        t_frame pending[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        static function longint half_away(longint v);
            if (v >= 0) begin
                return (v + 64'sd32768) >>> 16;
            end
            return -((-v + 64'sd32768) >>> 16);
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        static function void unit_vec(input longint v[3], output longint o[3]);
            longint unsigned mag[3], m, n2, r, q;
            int grow, shrink;
            m = 0; n2 = 0; grow = 0; shrink = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = v[i] < 0 ? -v[i] : v[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                o = '{0, 0, 0};
                return;
            end
            while (m >= (64'd1 << 31)) begin m >>= 1; shrink++; end
            while (m < (64'd1 << 30)) begin m <<= 1; grow++; end
            for (int i = 0; i < 3; i++) begin
                mag[i] = (mag[i] >> shrink) << grow;
                n2 += mag[i] * mag[i];
            end
            r = root(n2);
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] << 16) + (r >> 1)) / r;
                if (q > 65536) q = 65536;
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        endfunction

        static function longint shift_of(longint e[3], longint b[3]);
            return clip(-half_away(e[0] * b[0] + e[1] * b[1] + e[2] * b[2]),
                        -64'sd2147483648, 64'sd2147483647);
        endfunction

        function void note_request(lav_pkg::t_data in[9]);
            longint e[3], d[3], u[3], dn[3], pu[3], un[3], rt[3], t;
            t_frame f;
            for (int i = 0; i < 3; i++) begin
                e[i] = longint'(in[i]);
                d[i] = longint'(in[3 + i]) - e[i];
                u[i] = longint'(in[6 + i]);
            end
            unit_vec(d, dn);
            t = half_away(u[0] * dn[0] + u[1] * dn[1] + u[2] * dn[2]);
            for (int i = 0; i < 3; i++) pu[i] = u[i] - half_away(dn[i] * t);
            unit_vec(pu, un);
            rt[0] = clip(half_away(un[1] * dn[2] - un[2] * dn[1]), -65536, 65536);
            rt[1] = clip(half_away(un[2] * dn[0] - un[0] * dn[2]), -65536, 65536);
            rt[2] = clip(half_away(un[0] * dn[1] - un[1] * dn[0]), -65536, 65536);
            f.rx = lav_pkg::t_basis'(rt[0]);
            f.ry = lav_pkg::t_basis'(rt[1]);
            f.rz = lav_pkg::t_basis'(rt[2]);
            f.ux = lav_pkg::t_basis'(un[0]);
            f.uy = lav_pkg::t_basis'(un[1]);
            f.uz = lav_pkg::t_basis'(un[2]);
            f.dx = lav_pkg::t_basis'(dn[0]);
            f.dy = lav_pkg::t_basis'(dn[1]);
            f.dz = lav_pkg::t_basis'(dn[2]);
            f.sx = lav_pkg::t_data'(shift_of(e, rt));
            f.sy = lav_pkg::t_data'(shift_of(e, un));
            f.sz = lav_pkg::t_data'(shift_of(e, dn));
            pending.push_back(f);
        endfunction

        function void check_result(t_frame got);
            t_frame want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result", $realtime);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                errors++;
                $display("%0t: mismatch expected r=%0d,%0d,%0d u=%0d,%0d,%0d d=%0d,%0d,%0d",
                         $realtime, want.rx, want.ry, want.rz, want.ux, want.uy,
                         want.uz, want.dx, want.dy, want.dz);
                $display("    s=%0d,%0d,%0d actual r=%0d,%0d,%0d u=%0d,%0d,%0d",
                         want.sx, want.sy, want.sz, got.rx, got.ry, got.rz,
                         got.ux, got.uy, got.uz);
                $display("    d=%0d,%0d,%0d s=%0d,%0d,%0d", got.dx, got.dy, got.dz,
                         got.sx, got.sy, got.sz);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, o_valid;
    lav_pkg::t_data req[9];
    lav_pkg::t_basis o_right_x, o_right_y, o_right_z, o_ortho_up_x, o_ortho_up_y;
    lav_pkg::t_basis o_ortho_up_z, o_view_dir_x, o_view_dir_y, o_view_dir_z;
    lav_pkg::t_data o_shift_x, o_shift_y, o_shift_z;
    frame_scoreboard board;

    look_at_view_matrix_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_eye_x(req[0]), .i_eye_y(req[1]), .i_eye_z(req[2]),
        .i_target_x(req[3]), .i_target_y(req[4]), .i_target_z(req[5]),
        .i_upward_x(req[6]), .i_upward_y(req[7]), .i_upward_z(req[8]),
        .o_valid(o_valid),
        .o_right_x(o_right_x), .o_right_y(o_right_y), .o_right_z(o_right_z),
        .o_ortho_up_x(o_ortho_up_x), .o_ortho_up_y(o_ortho_up_y),
        .o_ortho_up_z(o_ortho_up_z),
        .o_view_dir_x(o_view_dir_x), .o_view_dir_y(o_view_dir_y),
        .o_view_dir_z(o_view_dir_z),
        .o_shift_x(o_shift_x), .o_shift_y(o_shift_y), .o_shift_z(o_shift_z)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    always @(posedge i_clk) begin
        t_frame got;
        if (i_rst_n && o_valid) begin
            got = '{o_right_x, o_right_y, o_right_z, o_ortho_up_x, o_ortho_up_y,
                    o_ortho_up_z, o_view_dir_x, o_view_dir_y, o_view_dir_z,
                    o_shift_x, o_shift_y, o_shift_z};
            board.check_result(got);
        end
    end

    // Presents one request and holds it until the unit takes it. Start stays
    // high back to back when there is no gap.
    task automatic send_camera(lav_pkg::t_data v[9], int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) req[i] <= v[i];
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(v);
    endtask

    function automatic lav_pkg::t_data pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 8;
            default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        lav_pkg::t_data v[9];
        int gap;
        board = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        for (int i = 0; i < 9; i++) req[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cameras: zero sight, zero up, up along sight, extremes.
        v = '{0, 0, 0, 0, 0, 0, 0, 32'h10000, 0};             send_camera(v, 0);
        v = '{0, 0, 0, 0, 0, 32'h10000, 0, 0, 0};             send_camera(v, 0);
        v = '{0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h30000};     send_camera(v, 0);
        v = '{1, 2, 3, 1, 2, 3, 5, 6, 7};                     send_camera(v, 1);
        v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 0};
        send_camera(v, 0);
        v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000};
        send_camera(v, 0);
        v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 1, 1};
        send_camera(v, 2);
        v = '{32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 32'h7fff0001, 32'h7fff0000,
              32'h7fff0000, 0, 32'h10000, 0};
        send_camera(v, 0);
        v = '{32'h12345678, 0, 0, 32'h12345678, 32'h1000, 0, 0, 32'h80000000, 0};
        send_camera(v, 0);
        v = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
              32'h10000};
        send_camera(v, 0);
        drain();

        for (int n = 0; n < 1500; n++) begin
            for (int i = 0; i < 9; i++) v[i] = pick_value();
            case ($urandom_range(0, 15))
                0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];
                1: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] - v[i];
                2: for (int i = 0; i < 3; i++) v[6 + i] = 0;
                default: ;
            endcase
            gap = ((n / 100) % 2 == 1) ? 0 : $urandom_range(0, 18);
            send_camera(v, gap);
            if (n == 700) drain();
        end
        drain();
        repeat (lav_pkg::OUT_LAT + 20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("look_at_view_matrix_unit regression: pass");
        end else begin
            $display("look_at_view_matrix_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("look_at_view_matrix_unit regression: fail");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/lav_pkg.sv
hw/rtl/lav_delay.sv
hw/rtl/lav_isqrt.sv
hw/rtl/lav_div.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix_unit.sv
dv/testbench.sv
